// ===== rtl/pbp_pkg.sv =====
`default_nettype none

package pbp_pkg;

  localparam int unsigned DefNumPages = 4096;
  localparam int unsigned DefNumSlots = 256;
  localparam logic [8:0]  LimitReset  = 9'd256;

  typedef enum logic [1:0] {
    REQ_PIN_CACHED = 2'd0,
    REQ_PIN_LOAD   = 2'd1,
    REQ_PIN_EMPTY  = 2'd2,
    REQ_UNPIN      = 2'd3
  } pbp_req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_CACHED = 2'd1,
    ST_NO_SLOT    = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } pbp_status_e;

  // Field enables for a partial write of one page entry.
  typedef struct packed {
    logic pin;
    logic has;
    logic slot;
    logic prev;
    logic next;
  } pbp_fld_t;

  localparam pbp_fld_t FldNone = '{default: 1'b0};
  localparam pbp_fld_t FldPin  = '{pin: 1'b1, default: 1'b0};
  localparam pbp_fld_t FldHas  = '{has: 1'b1, default: 1'b0};
  localparam pbp_fld_t FldSlot = '{slot: 1'b1, default: 1'b0};
  localparam pbp_fld_t FldPrev = '{prev: 1'b1, default: 1'b0};
  localparam pbp_fld_t FldNext = '{next: 1'b1, default: 1'b0};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CLR  = 8'b0000_0010,
    S_LOOK = 8'b0000_0100,
    S_VICT = 8'b0000_1000,
    S_WR0  = 8'b0001_0000,
    S_WR1  = 8'b0010_0000,
    S_WR2  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } pbp_state_e;

endpackage

`default_nettype wire

// ===== rtl/pbp_page_mem.sv =====
`default_nettype none

module pbp_page_mem
  import pbp_pkg::*;
#(
  parameter int unsigned NUM_PAGES = DefNumPages,
  parameter int unsigned NUM_SLOTS = DefNumSlots,
  localparam int unsigned PW = $clog2(NUM_PAGES),
  localparam int unsigned SW = $clog2(NUM_SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic [PW-1:0] rd_addr_i,
  output logic               rd_pin_o,
  output logic               rd_has_o,
  output logic [SW-1:0]      rd_slot_o,
  output logic [PW-1:0]      rd_prev_o,
  output logic [PW-1:0]      rd_next_o,
  input  wire logic          wr_en_i,
  input  wire logic [PW-1:0] wr_addr_i,
  input  wire pbp_fld_t      wr_fld_i,
  input  wire logic          wr_pin_i,
  input  wire logic          wr_has_i,
  input  wire logic [SW-1:0] wr_slot_i,
  input  wire logic [PW-1:0] wr_prev_i,
  input  wire logic [PW-1:0] wr_next_i
);

  typedef struct packed {
    logic          pin;
    logic          has;
    logic [SW-1:0] slot;
    logic [PW-1:0] prev;
    logic [PW-1:0] next;
  } entry_t;

  entry_t mem [NUM_PAGES];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (wr_fld_i.pin)  mem[wr_addr_i].pin  <= wr_pin_i;
      if (wr_fld_i.has)  mem[wr_addr_i].has  <= wr_has_i;
      if (wr_fld_i.slot) mem[wr_addr_i].slot <= wr_slot_i;
      if (wr_fld_i.prev) mem[wr_addr_i].prev <= wr_prev_i;
      if (wr_fld_i.next) mem[wr_addr_i].next <= wr_next_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_pin_o  = rd_q.pin;
  assign rd_has_o  = rd_q.has;
  assign rd_slot_o = rd_q.slot;
  assign rd_prev_o = rd_q.prev;
  assign rd_next_o = rd_q.next;

endmodule

`default_nettype wire

// ===== rtl/pbp_free_stack.sv =====
`default_nettype none

module pbp_free_stack
  import pbp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DefNumSlots,
  localparam int unsigned SW = $clog2(NUM_SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic [SW-1:0] rd_addr_i,
  output logic [SW-1:0]      rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [SW-1:0] wr_addr_i,
  input  wire logic [SW-1:0] wr_data_i
);

  logic [SW-1:0] mem [NUM_SLOTS];
  logic [SW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== rtl/pinned_page_buffer_pool.sv =====
// Buffer pool that binds page ids to buffer slots and keeps pins on them.
// A request (req_type_i, page_id_i) is taken at a clock edge with start_i
// high and busy_o low. The block then reads the page entry from the page
// table memory, reads the replacement list head when a slot must be taken
// over, and writes back up to three entries through the single write port.
// The result appears on the result ports for exactly one cycle with done_o
// high, after the states LOOK, WR0, WR1 and WR2, or LOOK, VICT, WR0, WR1
// and WR2 when a page is evicted. busy_o drops in the cycle after done_o;
// the serial reads, then three write slots of the page table set the length of a request.
// The receiver cannot stall; results must be taken in the cycle they show.
// The user writes soft_slot_limit through cfg_we_i/cfg_wdata_i only while
// idle; the block itself does not enforce this. After reset the block runs
// a clearing pass over all NUM_PAGES page table entries (4096 by default),
// one entry per cycle, with busy_o high; configuration writes are taken during it.
`default_nettype none

module pinned_page_buffer_pool
  import pbp_pkg::*;
#(
  parameter int unsigned NUM_PAGES = DefNumPages,
  parameter int unsigned NUM_SLOTS = DefNumSlots,
  localparam int unsigned SW = $clog2(NUM_SLOTS),
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] page_id_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [SW-1:0]    slot_index_o,
  output logic             load_needed_o,
  output logic             evicted_valid_o,
  output logic [11:0]      evicted_page_o,
  output logic [CW-1:0]    slots_in_use_o
);

  localparam int unsigned PW   = $clog2(NUM_PAGES);
  localparam int unsigned CMPW = (CW > 9) ? CW : 9;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] addr;
    pbp_fld_t      fld;
    logic          pin;
    logic          has;
    logic [SW-1:0] slot;
    logic [PW-1:0] prev;
    logic [PW-1:0] next;
  } wr_t;

  typedef struct packed {
    pbp_status_e   status;
    logic [SW-1:0] slot;
    logic          load;
    logic          evv;
    logic [PW-1:0] evp;
  } res_t;

  function automatic wr_t mk_wr(logic [PW-1:0] addr, pbp_fld_t fld, logic pin, logic has,
                                logic [SW-1:0] slot, logic [PW-1:0] prev,
                                logic [PW-1:0] next);
    wr_t w;
    w.vld  = 1'b1;
    w.addr = addr;
    w.fld  = fld;
    w.pin  = pin;
    w.has  = has;
    w.slot = slot;
    w.prev = prev;
    w.next = next;
    return w;
  endfunction

  pbp_state_e    state_q, state_d;
  logic [PW-1:0] clr_q, clr_d;
  logic [8:0]    limit_q;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic          empty_q, empty_d;
  logic [CW-1:0] count_q, count_d, top_q, top_d, fresh_q, fresh_d;
  pbp_req_e      req_q;
  logic [11:0]   page_q;
  wr_t           w_q [3];
  wr_t           w_d [3];
  res_t          res_q, res_d;

  logic [PW-1:0] rd_addr;
  logic          e_pin, e_has;
  logic [SW-1:0] e_slot;
  logic [PW-1:0] e_prev, e_next;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  wr_t           mem_w;

  logic [SW-1:0] stk_rdata;
  logic          stk_we;

  logic [PW-1:0] p_idx;
  logic          page_ok;
  logic          want_new, phys;
  logic [SW-1:0] new_slot;

  assign p_idx    = PW'(page_q);
  assign page_ok  = 32'(page_q) < NUM_PAGES;
  assign want_new = (CMPW'(count_q) < CMPW'(limit_q)) ||
                    (empty_q && (req_q != REQ_PIN_LOAD));
  assign phys     = (top_q != '0) || (fresh_q < CW'(NUM_SLOTS));
  assign new_slot = (top_q != '0) ? stk_rdata : fresh_q[SW-1:0];

  assign rd_addr = (state_q == S_LOOK) ? head_q : PW'(page_id_i);

  pbp_page_mem #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_page_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_pin_o  (e_pin),
    .rd_has_o  (e_has),
    .rd_slot_o (e_slot),
    .rd_prev_o (e_prev),
    .rd_next_o (e_next),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_fld_i  (mem_w.fld),
    .wr_pin_i  (mem_w.pin),
    .wr_has_i  (mem_w.has),
    .wr_slot_i (mem_w.slot),
    .wr_prev_i (mem_w.prev),
    .wr_next_i (mem_w.next)
  );

  pbp_free_stack #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_free_stack (
    .clk_i     (clk_i),
    .rd_addr_i (SW'(top_q - CW'(1))),
    .rd_data_o (stk_rdata),
    .wr_en_i   (stk_we),
    .wr_addr_i (top_q[SW-1:0]),
    .wr_data_i (e_slot)
  );

  // Write port: clearing pass first, then the three queued write slots.
  always_comb begin
    mem_w     = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    unique case (state_q)
      S_CLR: begin
        mem_we     = 1'b1;
        mem_w.fld  = FldPin | FldHas;
      end
      S_WR0: begin
        mem_w     = w_q[0];
        mem_we    = w_q[0].vld;
        mem_waddr = w_q[0].addr;
      end
      S_WR1: begin
        mem_w     = w_q[1];
        mem_we    = w_q[1].vld;
        mem_waddr = w_q[1].addr;
      end
      S_WR2: begin
        mem_w     = w_q[2];
        mem_we    = w_q[2].vld;
        mem_waddr = w_q[2].addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    count_d = count_q;
    top_d   = top_q;
    fresh_d = fresh_q;
    w_d     = w_q;
    res_d   = res_q;
    stk_we  = 1'b0;
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + PW'(1);
        if (clr_q == PW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        for (int i = 0; i < 3; i++) begin
          w_d[i].vld = 1'b0;
        end
        res_d   = '{status: ST_OK, slot: '0, load: 1'b0, evv: 1'b0, evp: '0};
        state_d = S_WR0;
        if (!page_ok) begin
          res_d.status = ST_NOT_CACHED;
        end else if (req_q == REQ_UNPIN) begin
          if (!e_pin) begin
            res_d.slot = e_has ? e_slot : '0;
          end else if (CMPW'(count_q) > CMPW'(limit_q)) begin
            if (top_q < CW'(NUM_SLOTS)) begin
              stk_we = 1'b1;
              top_d  = top_q + CW'(1);
            end
            count_d = count_q - CW'(1);
            w_d[0]  = mk_wr(p_idx, FldPin | FldHas, 1'b0, 1'b0, '0, '0, '0);
          end else begin
            res_d.slot = e_slot;
            if (empty_q) begin
              head_d  = p_idx;
              tail_d  = p_idx;
              empty_d = 1'b0;
              w_d[0]  = mk_wr(p_idx, FldPin, 1'b0, 1'b0, '0, '0, '0);
            end else begin
              w_d[0] = mk_wr(p_idx, FldPin | FldPrev, 1'b0, 1'b0, '0, tail_q, '0);
              w_d[1] = mk_wr(tail_q, FldNext, 1'b0, 1'b0, '0, '0, p_idx);
              tail_d = p_idx;
            end
          end
        end else if (req_q == REQ_PIN_CACHED && !e_has) begin
          res_d.status = ST_NOT_CACHED;
        end else if (e_pin) begin
          res_d.slot = e_slot;
          res_d.load = (req_q == REQ_PIN_LOAD);
        end else if (e_has) begin
          res_d.slot = e_slot;
          res_d.load = (req_q == REQ_PIN_LOAD);
          w_d[0]     = mk_wr(p_idx, FldPin, 1'b1, 1'b0, '0, '0, '0);
          if (!empty_q) begin
            if (p_idx == head_q && p_idx == tail_q) begin
              empty_d = 1'b1;
            end else if (p_idx == head_q) begin
              head_d = e_next;
            end else if (p_idx == tail_q) begin
              tail_d = e_prev;
            end else begin
              w_d[1] = mk_wr(e_prev, FldNext, 1'b0, 1'b0, '0, '0, e_next);
              w_d[2] = mk_wr(e_next, FldPrev, 1'b0, 1'b0, '0, e_prev, '0);
            end
          end
        end else if (want_new && phys) begin
          if (top_q != '0) begin
            top_d = top_q - CW'(1);
          end else begin
            fresh_d = fresh_q + CW'(1);
          end
          count_d    = count_q + CW'(1);
          res_d.slot = new_slot;
          res_d.load = (req_q == REQ_PIN_LOAD);
          w_d[0]     = mk_wr(p_idx, FldPin | FldHas | FldSlot, 1'b1, 1'b1, new_slot,
                             '0, '0);
        end else if (!empty_q) begin
          // The list head is read here and replaced in S_VICT.
          state_d = S_VICT;
        end else begin
          res_d.status = want_new ? ST_EXHAUSTED : ST_NO_SLOT;
        end
      end
      S_VICT: begin
        if (head_q == tail_q) begin
          empty_d = 1'b1;
        end else begin
          head_d = e_next;
        end
        res_d.slot = e_slot;
        res_d.load = (req_q == REQ_PIN_LOAD);
        res_d.evv  = 1'b1;
        res_d.evp  = head_q;
        w_d[0]     = mk_wr(head_q, FldHas, 1'b0, 1'b0, '0, '0, '0);
        w_d[1]     = mk_wr(p_idx, FldPin | FldHas | FldSlot, 1'b1, 1'b1, e_slot, '0, '0);
        state_d    = S_WR0;
      end
      S_WR0: state_d = S_WR1;
      S_WR1: state_d = S_WR2;
      S_WR2: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      limit_q <= LimitReset;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      count_q <= '0;
      top_q   <= '0;
      fresh_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      count_q <= count_d;
      top_q   <= top_d;
      fresh_q <= fresh_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q  <= pbp_req_e'(req_type_i);
      page_q <= page_id_i;
    end
    w_q   <= w_d;
    res_q <= res_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = res_q.status;
  assign slot_index_o    = res_q.slot;
  assign load_needed_o   = res_q.load;
  assign evicted_valid_o = res_q.evv;
  assign evicted_page_o  = 12'(res_q.evp);
  assign slots_in_use_o  = count_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted request did not raise busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(NUM_SLOTS) && fresh_q <= CW'(NUM_SLOTS))
    else $error("bound slot count beyond physical pool");

  a_evict_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> status_o == ST_OK)
    else $error("eviction reported on failed request");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pbp_pkg::*;

  localparam int Pages = 4096;
  localparam int Slots = 256;

  typedef struct packed {
    pbp_status_e status;
    logic [7:0]  slot;
    logic        load;
    logic        evv;
    logic [11:0] evp;
    logic [8:0]  inuse;
  } pool_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic [1:0]  req_type_i = '0;
  logic [11:0] page_id_i = '0;
  logic        busy_o, done_o, load_needed_o, evicted_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  slot_index_o;
  logic [11:0] evicted_page_o;
  logic [8:0]  slots_in_use_o;

  pinned_page_buffer_pool i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start_i, .busy_o,
    .req_type_i, .page_id_i, .done_o, .status_o, .slot_index_o,
    .load_needed_o, .evicted_valid_o, .evicted_page_o, .slots_in_use_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Shadow copy of the pool state.
  logic        pinned [Pages];
  logic        has    [Pages];
  logic [7:0]  slot_of[Pages];
  logic [11:0] prv    [Pages];
  logic [11:0] nxt    [Pages];
  logic [11:0] head, tail;
  logic        lru_empty;
  int          bound, stack_top, fresh, limit;
  logic [7:0]  free_stack[Slots];

  pool_res_t expected_q[$];
  int        mismatches;

  task automatic lru_unlink(input logic [11:0] p);
    logic [11:0] pv, nx;
    pv = prv[p];
    nx = nxt[p];
    if (lru_empty) return;
    if (p == head && p == tail) lru_empty = 1'b1;
    else if (p == head) head = nx;
    else if (p == tail) tail = pv;
    else begin
      nxt[pv] = nx;
      prv[nx] = pv;
    end
  endtask

  task automatic lru_append(input logic [11:0] p);
    if (lru_empty) begin
      head = p;
      tail = p;
      lru_empty = 1'b0;
    end else begin
      nxt[tail] = p;
      prv[p] = tail;
      tail = p;
    end
  endtask

  task automatic pin(input logic [11:0] p, input logic force_new, output pbp_status_e st,
                     output logic evv, output logic [11:0] evp);
    logic want_new, phys;
    logic [11:0] v;
    evv = 1'b0;
    evp = '0;
    st = ST_OK;
    if (pinned[p]) return;
    if (has[p]) begin
      lru_unlink(p);
      pinned[p] = 1'b1;
      return;
    end
    want_new = (bound < limit) || (lru_empty && force_new);
    phys = (stack_top > 0) || (fresh < Slots);
    if (want_new && phys) begin
      if (stack_top > 0) begin
        stack_top--;
        slot_of[p] = free_stack[stack_top];
      end else begin
        slot_of[p] = fresh[7:0];
        fresh++;
      end
      bound++;
    end else if (!lru_empty) begin
      v = head;
      lru_unlink(v);
      has[v] = 1'b0;
      slot_of[p] = slot_of[v];
      evv = 1'b1;
      evp = v;
    end else begin
      st = want_new ? ST_EXHAUSTED : ST_NO_SLOT;
      return;
    end
    has[p] = 1'b1;
    pinned[p] = 1'b1;
  endtask

  task automatic pool_predict(input pbp_req_e req, input logic [11:0] p, output pool_res_t r);
    r = '0;
    r.status = ST_OK;
    if (req == REQ_UNPIN) begin
      if (pinned[p]) begin
        pinned[p] = 1'b0;
        if (bound > limit) begin
          if (stack_top < Slots) begin
            free_stack[stack_top] = slot_of[p];
            stack_top++;
          end
          has[p] = 1'b0;
          bound--;
        end else begin
          lru_append(p);
        end
      end
      if (has[p]) r.slot = slot_of[p];
    end else if (req == REQ_PIN_CACHED && !has[p]) begin
      r.status = ST_NOT_CACHED;
    end else begin
      pin(p, req != REQ_PIN_LOAD, r.status, r.evv, r.evp);
      if (r.status == ST_OK) begin
        r.slot = slot_of[p];
        r.load = (req == REQ_PIN_LOAD);
      end else begin
        r.evv = 1'b0;
        r.evp = '0;
      end
    end
    r.inuse = bound[8:0];
  endtask

  // Leaves start high; callers lower it only when a gap follows.
  task automatic send_req(input pbp_req_e req, input logic [11:0] p);
    pool_res_t r;
    start_i    <= 1'b1;
    req_type_i <= req;
    page_id_i  <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pool_predict(req, p, r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    pause(1);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [8:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit = val;
  endtask

  always @(posedge clk_i) begin
    pool_res_t want, got;
    if (done_o) begin
      got = {pbp_status_e'(status_o), slot_index_o, load_needed_o, evicted_valid_o,
             evicted_page_o, slots_in_use_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d slot=%0d ld=%0b ev=%0b/%0d use=%0d,",
                      " got st=%0d slot=%0d ld=%0b ev=%0b/%0d use=%0d"},
                     want.status, want.slot, want.load, want.evv, want.evp, want.inuse,
                     got.status, got.slot, got.load, got.evv, got.evp, got.inuse);
        end
      end
    end
  end

  task automatic test_basic_pins();
    set_limit(9'd5);
    send_req(REQ_PIN_CACHED, 12'd0);
    send_req(REQ_PIN_LOAD, 12'd0);
    send_req(REQ_PIN_LOAD, 12'd0);
    send_req(REQ_PIN_EMPTY, 12'hFFF);
    send_req(REQ_UNPIN, 12'd7);
    send_req(REQ_UNPIN, 12'd0);
    send_req(REQ_PIN_CACHED, 12'd0);
    send_req(REQ_UNPIN, 12'd0);
    for (int i = 1; i <= 4; i++) send_req(REQ_PIN_LOAD, 12'(i * 273));
    // At the limit; page 0 was replaced by the fourth pin of the loop: no slot.
    send_req(REQ_PIN_LOAD, 12'hAAA);
    // Nothing unpinned now: a load pin finds no slot, an empty pin goes over.
    send_req(REQ_PIN_LOAD, 12'h555);
    send_req(REQ_PIN_EMPTY, 12'h555);
    send_req(REQ_UNPIN, 12'h555);
    send_req(REQ_UNPIN, 12'hFFF);
    send_req(REQ_PIN_CACHED, 12'hFFF);
    send_req(REQ_PIN_EMPTY, 12'hFFF);
    pause(2);
  endtask

  task automatic test_exhaustion();
    set_limit(9'd256);
    for (int i = 0; i < 260; i++) send_req(REQ_PIN_EMPTY, 12'(i + 3000));
    send_req(REQ_UNPIN, 12'd3100);
    send_req(REQ_PIN_EMPTY, 12'd100);
    for (int i = 0; i < 260; i++) send_req(REQ_UNPIN, 12'(i + 3000));
    pause(1);
  endtask

  task automatic test_random(input logic [8:0] lim, input int count, input int span);
    int burst;
    int gap;
    logic [11:0] p;
    set_limit(lim);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) pause(gap);
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 15) == 0) p = 12'($urandom);
      else p = 12'(3840 + $urandom_range(0, span - 1));
      send_req(pbp_req_e'($urandom_range(0, 3)), p);
    end
  endtask

  initial begin
    for (int i = 0; i < Pages; i++) begin
      pinned[i] = 1'b0;
      has[i] = 1'b0;
      slot_of[i] = '0;
      prv[i] = '0;
      nxt[i] = '0;
    end
    head = '0;
    tail = '0;
    lru_empty = 1'b1;
    bound = 0;
    stack_top = 0;
    fresh = 0;
    limit = 256;
    mismatches = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_pins();
    test_exhaustion();
    test_random(9'd7, 80, 16);
    test_random(9'd5, 70, 12);
    test_random(9'd511, 80, 256);
    test_random(9'd300, 80, 200);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
